// ===== src/hit_multiplicity_histogram_unit_defines.svh =====
// Assertion macros used by the checker file of the histogram unit.
`ifndef HIT_MULTIPLICITY_HISTOGRAM_UNIT_DEFINES_SVH
`define HIT_MULTIPLICITY_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define HMH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram unit check failed");

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define HMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram unit check failed");

`endif

// ===== src/hmh_pkg.sv =====
package hmh_pkg;

    // Command codes, echoed back as the result kind.
    typedef enum logic [1:0] {
        CMD_HIT   = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Bin address width that covers every supported histogram size (up to 128 bins).
    localparam int unsigned BIN_ADDR_W = 7;

    // Widths fixed by the item formats.
    localparam int unsigned ID_W    = 16;
    localparam int unsigned MULT_W  = 5;
    localparam int unsigned VALUE_W = 32;

    // One input item.
    typedef struct packed {
        cmd_t                command;
        logic [ID_W-1:0]     detector_id;
        logic [MULT_W-1:0]   bin_index;
    } in_item_t;

    // One result item.
    typedef struct packed {
        cmd_t                kind;
        logic [MULT_W-1:0]   multiplicity;
        logic [VALUE_W-1:0]  bin_value;
    } out_item_t;

    // Classified operation handed from the front end to the histogram back end.
    typedef struct packed {
        cmd_t                  cmd;
        logic [MULT_W-1:0]     multiplicity;
        logic                  in_range;
        logic [BIN_ADDR_W-1:0] addr;
    } op_t;

endpackage

// ===== src/hit_multiplicity_histogram_unit.sv =====
// Distinct-hit multiplicity histogram.
// Input channel in_valid/in_ready/in_data carries commands: a hit with its detector
// ID, close event, read bin, clear histogram. Every item gives exactly one result
// on out_valid/out_ready/out_data, in input order.
// The front end checks a hit against the event's ID set combinationally and takes one
// item per cycle while its queue has room. The back end finishes hits, clears and
// out-of-range reads from its idle state; closes and in-range bin reads wait in a
// second state for the registered read of the bin RAM, and closes then write the
// incremented bin back. An item passes through a queue slot and then the result
// register to out_valid; closes and in-range reads also pass the RAM read register.
// Sustained rate: one item per cycle for hits and clears while the receiver takes
// results; the back end takes no new item while a close or read waits for the RAM.
// Reset empties the queue, starts an empty event and clears all bins at once
// through per-bin valid bits. When the receiver stalls, the result register holds,
// the queue fills, and then in_ready drops.
module hit_multiplicity_histogram_unit #(
    parameter int unsigned MAX_BINS_HITS = 16,
    parameter int unsigned QUEUE_DEPTH   = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hmh_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hmh_pkg::out_item_t out_data
);

    logic         q_full;
    logic         q_push;
    hmh_pkg::op_t q_push_data;
    logic         q_pop;
    logic         q_head_valid;
    hmh_pkg::op_t q_head_data;

    // Event tracking and classification.
    hmh_front #(
        .MAX_BINS_HITS (MAX_BINS_HITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // Operation queue between front and back.
    hmh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // Histogram storage and result output.
    hmh_back #(
        .MAX_BINS_HITS (MAX_BINS_HITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_head_valid),
        .q_data    (q_head_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== src/hmh_ram.sv =====
module hmh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hmh_front.sv =====
module hmh_front #(
    parameter int unsigned MAX_BINS_HITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hmh_pkg::in_item_t in_data,
    input  logic             q_full,
    output logic             q_push,
    output hmh_pkg::op_t     q_data
);

    localparam int unsigned CNT_W = $clog2(MAX_BINS_HITS + 1);
    localparam int unsigned IDX_W = (MAX_BINS_HITS > 1) ? $clog2(MAX_BINS_HITS) : 1;

    logic [hmh_pkg::ID_W-1:0] seen_ids_reg [MAX_BINS_HITS];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     overflow_reg;
    logic                     overflow_next;
    logic [MAX_BINS_HITS-1:0] match;
    logic                     known;
    logic                     store_id;
    logic [CNT_W-1:0]         binned;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    // Parallel compare of the hit ID against the occupied part of the ID set.
    always_comb
    begin
        for (int i = 0; i < MAX_BINS_HITS; i++)
        begin
            match[i] = (seen_ids_reg[i] == in_data.detector_id) &&
                       (CNT_W'(i) < count_reg);
        end
    end

    assign known  = |match;
    assign binned = overflow_reg ? CNT_W'(MAX_BINS_HITS) : count_reg;

    // Event bookkeeping and classification of the item for the back end.
    always_comb
    begin
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        store_id          = 1'b0;
        q_data.cmd        = in_data.command;
        q_data.in_range   = 1'b0;
        q_data.addr       = '0;
        unique case (in_data.command)
            hmh_pkg::CMD_HIT:
            begin
                if (!known)
                begin
                    if (count_reg < CNT_W'(MAX_BINS_HITS))
                    begin
                        store_id   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end
            hmh_pkg::CMD_CLOSE:
            begin
                count_next      = '0;
                overflow_next   = 1'b0;
                q_data.in_range = 1'b1;
                q_data.addr     = hmh_pkg::BIN_ADDR_W'(binned);
            end
            hmh_pkg::CMD_READ:
            begin
                q_data.in_range = hmh_pkg::BIN_ADDR_W'(in_data.bin_index) <=
                                  hmh_pkg::BIN_ADDR_W'(MAX_BINS_HITS);
                q_data.addr     = hmh_pkg::BIN_ADDR_W'(in_data.bin_index);
            end
            hmh_pkg::CMD_CLEAR:
            begin
                q_data.in_range = 1'b0;
            end
        endcase
        // A close reports the binned multiplicity; the rest report the running count.
        if (in_data.command == hmh_pkg::CMD_CLOSE)
        begin
            q_data.multiplicity = hmh_pkg::MULT_W'(binned);
        end
        else
        begin
            q_data.multiplicity = hmh_pkg::MULT_W'(count_next);
        end
    end

    // Event state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (q_push)
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // ID set storage; entries at or above the count are never compared.
    always_ff @(posedge clk)
    begin
        if (q_push && store_id)
        begin
            seen_ids_reg[count_reg[IDX_W-1:0]] <= in_data.detector_id;
        end
    end

endmodule

// ===== src/hmh_queue.sv =====
module hmh_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hmh_pkg::op_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output hmh_pkg::op_t head_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hmh_pkg::op_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slots_reg[rd_ptr_reg];

    // Occupancy tracks pushes and pops in the same cycle.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/hmh_back.sv =====
module hmh_back #(
    parameter int unsigned MAX_BINS_HITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hmh_pkg::op_t       q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output hmh_pkg::out_item_t out_data
);

    localparam int unsigned NUM_BINS = MAX_BINS_HITS + 1;
    localparam int unsigned BIN_W    = $clog2(NUM_BINS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WAIT = 2'b10
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    hmh_pkg::op_t                  pending_reg;
    hmh_pkg::op_t                  pending_next;
    logic [NUM_BINS-1:0]           bin_valid_reg;
    logic [NUM_BINS-1:0]           bin_valid_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    hmh_pkg::out_item_t            out_data_reg;
    hmh_pkg::out_item_t            out_data_next;
    logic                          load_out;
    logic                          out_free;
    logic                          ram_re;
    logic                          ram_we;
    logic [BIN_W-1:0]              head_addr;
    logic [BIN_W-1:0]              pend_addr;
    logic [hmh_pkg::VALUE_W-1:0]   ram_rdata;
    logic [hmh_pkg::VALUE_W-1:0]   bin_now;
    logic [hmh_pkg::VALUE_W-1:0]   bin_bumped;

    hmh_ram #(
        .WIDTH (hmh_pkg::VALUE_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pend_addr),
        .wdata (bin_bumped),
        .re    (ram_re),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign head_addr  = q_data.addr[BIN_W-1:0];
    assign pend_addr  = pending_reg.addr[BIN_W-1:0];

    // A bin not written since the last clear reads as zero; the count saturates.
    assign bin_now    = bin_valid_reg[pend_addr] ? ram_rdata : '0;
    assign bin_bumped = (bin_now == '1) ? bin_now : bin_now + hmh_pkg::VALUE_W'(1);

    // Sequencer: closes and in-range bin reads wait for the registered RAM read, everything else finishes at once.
    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        bin_valid_next = bin_valid_reg;
        out_data_next  = out_data_reg;
        load_out       = 1'b0;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop                      = 1'b1;
                    out_data_next.kind         = q_data.cmd;
                    out_data_next.multiplicity = q_data.multiplicity;
                    out_data_next.bin_value    = '0;
                    if (q_data.in_range &&
                        (q_data.cmd == hmh_pkg::CMD_CLOSE || q_data.cmd == hmh_pkg::CMD_READ))
                    begin
                        ram_re       = 1'b1;
                        pending_next = q_data;
                        state_next   = ST_WAIT;
                    end
                    else
                    begin
                        load_out = 1'b1;
                        if (q_data.cmd == hmh_pkg::CMD_CLEAR)
                        begin
                            bin_valid_next = '0;
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    load_out                   = 1'b1;
                    out_data_next.kind         = pending_reg.cmd;
                    out_data_next.multiplicity = pending_reg.multiplicity;
                    if (pending_reg.cmd == hmh_pkg::CMD_CLOSE)
                    begin
                        ram_we                    = 1'b1;
                        bin_valid_next[pend_addr] = 1'b1;
                        out_data_next.bin_value   = bin_bumped;
                    end
                    else
                    begin
                        out_data_next.bin_value = bin_now;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register holds a result until the receiver takes it.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_valid_reg <= bin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pending_reg  <= pending_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/hmh_checker.sv =====
`include "hit_multiplicity_histogram_unit_defines.svh"

module hmh_checker #(
    parameter int unsigned MAX_BINS_HITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input hmh_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input hmh_pkg::out_item_t out_data
);

    // A waiting input item stays put.
    `HMH_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

    // A stalled result stays put.
    `HMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Hits and clears carry no bin count.
    `HMH_ASSERT_NOW(a_zero_value,
        out_valid && (out_data.kind == hmh_pkg::CMD_HIT || out_data.kind == hmh_pkg::CMD_CLEAR),
        out_data.bin_value == '0)

    // A closed event's bin has just been incremented, so it is never zero.
    `HMH_ASSERT_NOW(a_close_nonzero,
        out_valid && out_data.kind == hmh_pkg::CMD_CLOSE,
        out_data.bin_value != '0)

    // After a hit the event holds at least one distinct ID.
    `HMH_ASSERT_NOW(a_hit_counted,
        out_valid && out_data.kind == hmh_pkg::CMD_HIT,
        MAX_BINS_HITS >= 32 || out_data.multiplicity != '0)

endmodule

bind hit_multiplicity_histogram_unit hmh_checker #(
    .MAX_BINS_HITS (MAX_BINS_HITS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
